// ===== rtl/core/kalc_pkg.sv =====
`default_nettype none

package kalc_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] KIND_FRAME_START = 2'd0;
    localparam logic [1:0] KIND_KEY_EVENT   = 2'd1;
    localparam logic [1:0] KIND_FRAME_END   = 2'd2;

    // key values
    localparam logic [1:0] KEY_RELEASED = 2'd0;
    localparam logic [1:0] KEY_PRESSED  = 2'd1;
    localparam logic [1:0] KEY_REPEAT   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_VOLUME_MAX      = 3'd0;
    localparam logic [2:0] REG_BRIGHTNESS_MAX  = 3'd1;
    localparam logic [2:0] REG_REPEAT_DELAY    = 3'd2;
    localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd3;
    localparam logic [2:0] REG_SLEEP_GAP       = 3'd4;
    localparam logic [2:0] REG_MENU_KEY        = 3'd5;
    localparam logic [2:0] REG_PLUS_KEY        = 3'd6;
    localparam logic [2:0] REG_MINUS_KEY       = 3'd7;

    localparam int LEVEL_W    = 6;
    localparam int MS_W       = 16;
    localparam int CODE_W     = 10;
    localparam int STAMP_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;

    // register reset values
    localparam logic [LEVEL_W-1:0] VOLUME_MAX_RST      = 6'd20;
    localparam logic [LEVEL_W-1:0] BRIGHTNESS_MAX_RST  = 6'd10;
    localparam logic [MS_W-1:0]    REPEAT_DELAY_RST    = 16'd300;
    localparam logic [MS_W-1:0]    REPEAT_INTERVAL_RST = 16'd100;
    localparam logic [MS_W-1:0]    SLEEP_GAP_RST       = 16'd1000;
    localparam logic [CODE_W-1:0]  MENU_KEY_RST        = 10'd312;
    localparam logic [CODE_W-1:0]  PLUS_KEY_RST        = 10'd115;
    localparam logic [CODE_W-1:0]  MINUS_KEY_RST       = 10'd114;

    // input beat payload, msb first
    typedef struct packed {
        logic [LEVEL_W-1:0] brightness_now;
        logic [LEVEL_W-1:0] volume_now;
        logic [1:0]         key_value;
        logic [CODE_W-1:0]  key_code;
        logic [STAMP_W-1:0] time_ms;
    } in_data_t;

    // input side-band, msb first
    typedef struct packed {
        logic       is_key_event;
        logic [1:0] kind;
    } in_user_t;

    // result payload, msb first
    typedef struct packed {
        logic               brightness_changed;
        logic               volume_changed;
        logic [LEVEL_W-1:0] brightness_new;
        logic [LEVEL_W-1:0] volume_new;
    } out_data_t;

endpackage

`default_nettype wire

// ===== rtl/core/key_autorepeat_level_control_core.sv =====
// channel   | dir | handshake                    | payload (lsb first)
// ----------+-----+------------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: time_ms, key_code, key_value,
//           |     |                              |   volume_now, brightness_now; tuser: kind,
//           |     |                              |   is_key_event
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: volume_new, brightness_new,
//           |     |                              |   volume_changed, brightness_changed
// cfg       | in  | cfg_we (no back-pressure)    | cfg_addr, cfg_wdata
//
// one beat per cycle sustained while the result side takes results; a frame end's result is held
// in the input register, then in the result register, around one pass of logic
// reset (aresetn low, synchronous) clears the key state, time stamps and config to defaults
// a stalled result register stalls the input register; the input side keeps taking beats
// while the result register is free or being drained in the same cycle

`default_nettype none

module key_autorepeat_level_control_core #(
    parameter int TIME_BITS = 32
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // time_ms[31:0], key_code[41:32], key_value[43:42], volume_now[49:44],
    // brightness_now[55:50]
    input  wire  [kalc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0], is_key_event[2]
    input  wire  [kalc_pkg::S_TUSER_W-1:0]   s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // volume_new[5:0], brightness_new[11:6], volume_changed[12],
    // brightness_changed[13], zero pad[15:14]
    output logic [kalc_pkg::M_TDATA_W-1:0]   m_axis_tdata,

    input  wire                              cfg_we,
    input  wire  [kalc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [kalc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int LW = kalc_pkg::LEVEL_W;
    localparam int MW = kalc_pkg::MS_W;
    localparam int CW = kalc_pkg::CODE_W;
    localparam int SW = kalc_pkg::STAMP_W;

    // configuration registers
    logic [LW-1:0] volume_max_reg;
    logic [LW-1:0] brightness_max_reg;
    logic [MW-1:0] repeat_delay_reg;
    logic [MW-1:0] repeat_interval_reg;
    logic [MW-1:0] sleep_gap_reg;
    logic [CW-1:0] menu_key_reg;
    logic [CW-1:0] plus_key_reg;
    logic [CW-1:0] minus_key_reg;

    // input register
    logic                 in_vld_reg;
    kalc_pkg::in_data_t   in_data_reg;
    kalc_pkg::in_user_t   in_user_reg;

    // result register
    logic                 out_vld_reg;
    kalc_pkg::out_data_t  out_data_reg;
    kalc_pkg::out_data_t  out_data_next;

    // key handler state
    logic [TIME_BITS-1:0] frame_time_reg,  frame_time_next;
    logic [TIME_BITS-1:0] prev_time_reg,   prev_time_next;
    logic                 discard_reg,     discard_next;
    logic                 menu_held_reg,   menu_held_next;
    logic                 up_held_reg,     up_held_next;
    logic                 up_fresh_reg,    up_fresh_next;
    logic [TIME_BITS-1:0] up_repeat_reg,   up_repeat_next;
    logic                 down_held_reg,   down_held_next;
    logic                 down_fresh_reg,  down_fresh_next;
    logic [TIME_BITS-1:0] down_repeat_reg, down_repeat_next;

    logic advance;

    // widened views, cut to the time width
    logic [TIME_BITS+SW-1:0] stamp_wide;
    logic [TIME_BITS+MW-1:0] delay_wide;
    logic [TIME_BITS+MW-1:0] interval_wide;
    logic [TIME_BITS+MW-1:0] gap_limit_wide;
    logic [TIME_BITS-1:0]    stamp_t;
    logic [TIME_BITS-1:0]    delay_t;
    logic [TIME_BITS-1:0]    interval_t;
    logic [TIME_BITS-1:0]    gap_limit_t;

    // frame end datapath
    logic          menu_e, up_held_e, up_fresh_e, down_held_e, down_fresh_e;
    logic [TIME_BITS-1:0] up_repeat_e, down_repeat_e;
    logic          up_go, down_go;
    logic [LW-1:0] lvl_sel, lvl_max, lvl_up, lvl_dn;
    logic          up_ok, down_ok, stepped;
    logic          key_ok, key_on;

    assign stamp_wide     = {{TIME_BITS{1'b0}}, in_data_reg.time_ms};
    assign delay_wide     = {{TIME_BITS{1'b0}}, repeat_delay_reg};
    assign interval_wide  = {{TIME_BITS{1'b0}}, repeat_interval_reg};
    assign gap_limit_wide = {{TIME_BITS{1'b0}}, sleep_gap_reg};
    assign stamp_t        = stamp_wide[TIME_BITS-1:0];
    assign delay_t        = delay_wide[TIME_BITS-1:0];
    assign interval_t     = interval_wide[TIME_BITS-1:0];
    assign gap_limit_t    = gap_limit_wide[TIME_BITS-1:0];

    // the held item moves on when the result register is free or drains now
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(kalc_pkg::M_TDATA_W - $bits(kalc_pkg::out_data_t)){1'b0}},
                            out_data_reg};

    // a discarded frame end sees all marks cleared
    assign menu_e        = menu_held_reg   && !discard_reg;
    assign up_held_e     = up_held_reg     && !discard_reg;
    assign up_fresh_e    = up_fresh_reg    && !discard_reg;
    assign down_held_e   = down_held_reg   && !discard_reg;
    assign down_fresh_e  = down_fresh_reg  && !discard_reg;
    assign up_repeat_e   = discard_reg ? '0 : up_repeat_reg;
    assign down_repeat_e = discard_reg ? '0 : down_repeat_reg;

    assign up_go   = up_fresh_e   || (up_held_e   && (frame_time_reg >= up_repeat_e));
    assign down_go = down_fresh_e || (down_held_e && (frame_time_reg >= down_repeat_e));

    // up then down on the level menu selects, saturating at zero and max
    assign lvl_sel = menu_e ? in_data_reg.brightness_now : in_data_reg.volume_now;
    assign lvl_max = menu_e ? brightness_max_reg : volume_max_reg;
    assign up_ok   = up_go && (lvl_sel < lvl_max);
    assign lvl_up  = up_ok ? lvl_sel + LW'(1) : lvl_sel;
    assign down_ok = down_go && (lvl_up != '0);
    assign lvl_dn  = down_ok ? lvl_up - LW'(1) : lvl_up;
    assign stepped = up_ok || down_ok;

    // key events outside a discarded frame with a known value
    assign key_ok = !discard_reg && in_user_reg.is_key_event
                    && (in_data_reg.key_value == kalc_pkg::KEY_RELEASED
                        || in_data_reg.key_value == kalc_pkg::KEY_PRESSED
                        || in_data_reg.key_value == kalc_pkg::KEY_REPEAT);
    assign key_on = in_data_reg.key_value != kalc_pkg::KEY_RELEASED;

    always_comb begin
        frame_time_next  = frame_time_reg;
        prev_time_next   = prev_time_reg;
        discard_next     = discard_reg;
        menu_held_next   = menu_held_reg;
        up_held_next     = up_held_reg;
        up_fresh_next    = up_fresh_reg;
        up_repeat_next   = up_repeat_reg;
        down_held_next   = down_held_reg;
        down_fresh_next  = down_fresh_reg;
        down_repeat_next = down_repeat_reg;

        out_data_next.volume_new         = menu_e ? in_data_reg.volume_now : lvl_dn;
        out_data_next.brightness_new     = menu_e ? lvl_dn : in_data_reg.brightness_now;
        out_data_next.volume_changed     = !menu_e && stepped;
        out_data_next.brightness_changed = menu_e && stepped;

        case (in_user_reg.kind)
            kalc_pkg::KIND_FRAME_START: begin
                frame_time_next = stamp_t;
                // wrapping gap since the last frame end
                if ((stamp_t - prev_time_reg) > gap_limit_t) begin
                    discard_next = 1'b1;
                end
            end
            kalc_pkg::KIND_KEY_EVENT: begin
                if (key_ok) begin
                    if (in_data_reg.key_code == menu_key_reg) begin
                        menu_held_next = key_on;
                    end else if (in_data_reg.key_code == plus_key_reg) begin
                        up_held_next  = key_on;
                        up_fresh_next = key_on;
                        if (key_on) begin
                            up_repeat_next = frame_time_reg + delay_t;
                        end
                    end else if (in_data_reg.key_code == minus_key_reg) begin
                        down_held_next  = key_on;
                        down_fresh_next = key_on;
                        if (key_on) begin
                            down_repeat_next = frame_time_reg + delay_t;
                        end
                    end
                end
            end
            kalc_pkg::KIND_FRAME_END: begin
                menu_held_next   = menu_e;
                up_held_next     = up_held_e;
                down_held_next   = down_held_e;
                up_fresh_next    = up_fresh_e && !up_go;
                down_fresh_next  = down_fresh_e && !down_go;
                up_repeat_next   = (up_go && !up_fresh_e) ? up_repeat_e + interval_t
                                                          : up_repeat_e;
                down_repeat_next = (down_go && !down_fresh_e) ? down_repeat_e + interval_t
                                                              : down_repeat_e;
                prev_time_next   = frame_time_reg;
                discard_next     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_max_reg      <= kalc_pkg::VOLUME_MAX_RST;
            brightness_max_reg  <= kalc_pkg::BRIGHTNESS_MAX_RST;
            repeat_delay_reg    <= kalc_pkg::REPEAT_DELAY_RST;
            repeat_interval_reg <= kalc_pkg::REPEAT_INTERVAL_RST;
            sleep_gap_reg       <= kalc_pkg::SLEEP_GAP_RST;
            menu_key_reg        <= kalc_pkg::MENU_KEY_RST;
            plus_key_reg        <= kalc_pkg::PLUS_KEY_RST;
            minus_key_reg       <= kalc_pkg::MINUS_KEY_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                kalc_pkg::REG_VOLUME_MAX:      volume_max_reg      <= cfg_wdata[LW-1:0];
                kalc_pkg::REG_BRIGHTNESS_MAX:  brightness_max_reg  <= cfg_wdata[LW-1:0];
                kalc_pkg::REG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_wdata[MW-1:0];
                kalc_pkg::REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_wdata[MW-1:0];
                kalc_pkg::REG_SLEEP_GAP:       sleep_gap_reg       <= cfg_wdata[MW-1:0];
                kalc_pkg::REG_MENU_KEY:        menu_key_reg        <= cfg_wdata[CW-1:0];
                kalc_pkg::REG_PLUS_KEY:        plus_key_reg        <= cfg_wdata[CW-1:0];
                kalc_pkg::REG_MINUS_KEY:       minus_key_reg       <= cfg_wdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= kalc_pkg::in_data_t'(s_axis_tdata);
            in_user_reg <= kalc_pkg::in_user_t'(s_axis_tuser);
        end
    end

    // key state, updated as each beat leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_time_reg  <= '0;
            prev_time_reg   <= '0;
            discard_reg     <= 1'b0;
            menu_held_reg   <= 1'b0;
            up_held_reg     <= 1'b0;
            up_fresh_reg    <= 1'b0;
            up_repeat_reg   <= '0;
            down_held_reg   <= 1'b0;
            down_fresh_reg  <= 1'b0;
            down_repeat_reg <= '0;
        end else if (advance) begin
            frame_time_reg  <= frame_time_next;
            prev_time_reg   <= prev_time_next;
            discard_reg     <= discard_next;
            menu_held_reg   <= menu_held_next;
            up_held_reg     <= up_held_next;
            up_fresh_reg    <= up_fresh_next;
            up_repeat_reg   <= up_repeat_next;
            down_held_reg   <= down_held_next;
            down_fresh_reg  <= down_fresh_next;
            down_repeat_reg <= down_repeat_next;
        end
    end

    // result register, loaded by frame ends only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_user_reg.kind == kalc_pkg::KIND_FRAME_END) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_user_reg.kind == kalc_pkg::KIND_FRAME_END) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kalc_checker.sv =====
`default_nettype none

module kalc_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire [kalc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [kalc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int LW = kalc_pkg::LEVEL_W;

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // a fresh result follows a frame end taken through the input and result registers
    a_result_from_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready
                  && s_axis_tuser[1:0] == kalc_pkg::KIND_FRAME_END, 2))
        else $error("result beat without a frame end");

    // steps of one frame go to a single level
    a_one_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[2*LW] && m_axis_tdata[2*LW+1]))
        else $error("volume and brightness both changed in one frame");

endmodule

bind key_autorepeat_level_control_core kalc_checker u_kalc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/key_autorepeat_level_control_core_test.sv =====
`timescale 1ns / 1ps

module key_autorepeat_level_control_core_test;

    // codes the package leaves out
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] KEY_IGNORED = 2'd3;

    localparam int LEVEL_W      = kalc_pkg::LEVEL_W;
    localparam int MS_W         = kalc_pkg::MS_W;
    localparam int CODE_W       = kalc_pkg::CODE_W;
    localparam int REPORT_W     = $bits(kalc_pkg::out_data_t);
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_GAP   = 4;

    // one pending input beat, hold means wait for every report before sending
    typedef struct packed {
        logic               hold;
        kalc_pkg::in_user_t u;
        kalc_pkg::in_data_t d;
    } key_beat_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // time_ms, key_code, key_value, volume_now, brightness_now from lsb up
    logic [kalc_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    // kind, is_key_event from lsb up
    logic [kalc_pkg::S_TUSER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // volume_new, brightness_new, volume_changed, brightness_changed from lsb up
    logic [kalc_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            cfg_we;
    logic [kalc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [kalc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    key_autorepeat_level_control_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // stimulus and scoreboard bookkeeping
    key_beat_t           pending_beats[$];
    kalc_pkg::out_data_t level_reports_due[$];
    key_beat_t           on_wire;
    logic                beat_taken;
    logic                steady_run;
    int unsigned         beats_queued;
    int unsigned         beats_taken;
    int unsigned         reports_checked;
    int unsigned         settings_used;
    int unsigned         fails;
    int unsigned         cycles;
    logic [31:0]         stim_clock;

    // shadow of the register file
    logic [LEVEL_W-1:0] vol_cap, bri_cap;
    logic [MS_W-1:0]    delay_cfg, interval_cfg, gap_cfg;
    logic [CODE_W-1:0]  menu_code, plus_code, minus_code;

    // shadow of the key state
    logic [31:0] cur_stamp, last_stamp, raise_due, lower_due;
    logic        skip_frame, menu_on;
    logic        raise_held, raise_new, lower_held, lower_new;

    // saturating one-step move of a level
    function automatic void nudge(inout logic [LEVEL_W-1:0] lvl,
                                  input logic [LEVEL_W-1:0] cap,
                                  input logic up, inout logic moved);
        if (up) begin
            if (lvl < cap) begin
                lvl   = lvl + LEVEL_W'(1);
                moved = 1'b1;
            end
        end else if (lvl != '0) begin
            lvl   = lvl - LEVEL_W'(1);
            moved = 1'b1;
        end
    endfunction

    // advance the shadow key state by one accepted beat, queue any level report
    task automatic track_key_beat(input kalc_pkg::in_user_t u, input kalc_pkg::in_data_t d);
        logic [31:0]         span;
        logic [LEVEL_W-1:0]  vol, bri;
        logic                vchg, bchg, on;
        kalc_pkg::out_data_t rpt;
        case (u.kind)
            kalc_pkg::KIND_FRAME_START: begin
                cur_stamp = d.time_ms;
                span = cur_stamp - last_stamp;
                if (span > {16'd0, gap_cfg})
                    skip_frame = 1'b1;
            end
            kalc_pkg::KIND_KEY_EVENT: begin
                on = (d.key_value != kalc_pkg::KEY_RELEASED);
                if (!skip_frame && u.is_key_event && d.key_value != KEY_IGNORED) begin
                    // menu wins over plus, plus over minus on shared codes
                    if (d.key_code == menu_code) begin
                        menu_on = on;
                    end else if (d.key_code == plus_code) begin
                        raise_held = on;
                        raise_new  = on;
                        if (on)
                            raise_due = cur_stamp + {16'd0, delay_cfg};
                    end else if (d.key_code == minus_code) begin
                        lower_held = on;
                        lower_new  = on;
                        if (on)
                            lower_due = cur_stamp + {16'd0, delay_cfg};
                    end
                end
            end
            kalc_pkg::KIND_FRAME_END: begin
                vol  = d.volume_now;
                bri  = d.brightness_now;
                vchg = 1'b0;
                bchg = 1'b0;
                if (skip_frame) begin
                    menu_on    = 1'b0;
                    raise_held = 1'b0;
                    raise_new  = 1'b0;
                    lower_held = 1'b0;
                    lower_new  = 1'b0;
                    raise_due  = '0;
                    lower_due  = '0;
                end
                if (raise_new || (raise_held && cur_stamp >= raise_due)) begin
                    if (menu_on)
                        nudge(bri, bri_cap, 1'b1, bchg);
                    else
                        nudge(vol, vol_cap, 1'b1, vchg);
                    if (raise_new)
                        raise_new = 1'b0;
                    else
                        raise_due = raise_due + {16'd0, interval_cfg};
                end
                if (lower_new || (lower_held && cur_stamp >= lower_due)) begin
                    if (menu_on)
                        nudge(bri, bri_cap, 1'b0, bchg);
                    else
                        nudge(vol, vol_cap, 1'b0, vchg);
                    if (lower_new)
                        lower_new = 1'b0;
                    else
                        lower_due = lower_due + {16'd0, interval_cfg};
                end
                last_stamp = cur_stamp;
                skip_frame = 1'b0;
                rpt.volume_new         = vol;
                rpt.brightness_new     = bri;
                rpt.volume_changed     = vchg;
                rpt.brightness_changed = bchg;
                level_reports_due.push_back(rpt);
            end
            default: begin
                // unused kind leaves everything alone
            end
        endcase
    endtask

    // scoreboard side: track accepted input beats, check result beats
    always @(posedge aclk) begin
        cycles = cycles + 1;
        beat_taken = aresetn && s_axis_tvalid && s_axis_tready;
        if (beat_taken) begin
            beats_taken = beats_taken + 1;
            track_key_beat(kalc_pkg::in_user_t'(s_axis_tuser),
                           kalc_pkg::in_data_t'(s_axis_tdata));
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            kalc_pkg::out_data_t seen, want;
            seen = m_axis_tdata[REPORT_W-1:0];
            if (level_reports_due.size() == 0) begin
                $error("level report with no frame end pending: %h", m_axis_tdata);
                fails = fails + 1;
            end else begin
                want = level_reports_due.pop_front();
                reports_checked = reports_checked + 1;
                if (seen.volume_new != want.volume_new) begin
                    $error("volume_new: expected %0d, got %0d",
                           want.volume_new, seen.volume_new);
                    fails = fails + 1;
                end
                if (seen.brightness_new != want.brightness_new) begin
                    $error("brightness_new: expected %0d, got %0d",
                           want.brightness_new, seen.brightness_new);
                    fails = fails + 1;
                end
                if (seen.volume_changed != want.volume_changed) begin
                    $error("volume_changed: expected %0d, got %0d",
                           want.volume_changed, seen.volume_changed);
                    fails = fails + 1;
                end
                if (seen.brightness_changed != want.brightness_changed) begin
                    $error("brightness_changed: expected %0d, got %0d",
                           want.brightness_changed, seen.brightness_changed);
                    fails = fails + 1;
                end
            end
        end
        // watchdog
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d reports still due",
                     cycles, level_reports_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // sender: next beat goes out once the current one is taken, with random gaps outside a steady run
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || beat_taken) begin
            if (pending_beats.size() != 0
                && !(pending_beats[0].hold && level_reports_due.size() != 0)
                && (steady_run || $urandom_range(0, 99) >= 33)) begin
                on_wire = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= on_wire.d;
                s_axis_tuser  <= on_wire.u;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: back-pressure about a third of the time outside a steady run
    always @(negedge aclk) begin
        m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 33);
    end

    task automatic push_beat(input logic [1:0] kind, input logic [31:0] t,
                             input logic is_key, input logic [CODE_W-1:0] code,
                             input logic [1:0] value, input logic [LEVEL_W-1:0] vol,
                             input logic [LEVEL_W-1:0] bri, input logic hold);
        key_beat_t b;
        b.hold             = hold;
        b.u.kind           = kind;
        b.u.is_key_event   = is_key;
        b.d.time_ms        = t;
        b.d.key_code       = code;
        b.d.key_value      = value;
        b.d.volume_now     = vol;
        b.d.brightness_now = bri;
        pending_beats.push_back(b);
        beats_queued = beats_queued + 1;
    endtask

    // register write, shadow copy updated before the write is driven
    task automatic write_reg(input logic [kalc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [kalc_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            kalc_pkg::REG_VOLUME_MAX:      vol_cap      = val[LEVEL_W-1:0];
            kalc_pkg::REG_BRIGHTNESS_MAX:  bri_cap      = val[LEVEL_W-1:0];
            kalc_pkg::REG_REPEAT_DELAY:    delay_cfg    = val;
            kalc_pkg::REG_REPEAT_INTERVAL: interval_cfg = val;
            kalc_pkg::REG_SLEEP_GAP:       gap_cfg      = val;
            kalc_pkg::REG_MENU_KEY:        menu_code    = val[CODE_W-1:0];
            kalc_pkg::REG_PLUS_KEY:        plus_code    = val[CODE_W-1:0];
            kalc_pkg::REG_MINUS_KEY:       minus_code   = val[CODE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] vmax, input logic [15:0] bmax,
                                 input logic [15:0] delay, input logic [15:0] intv,
                                 input logic [15:0] gap, input logic [15:0] menu,
                                 input logic [15:0] plus, input logic [15:0] minus);
        write_reg(kalc_pkg::REG_VOLUME_MAX, vmax);
        write_reg(kalc_pkg::REG_BRIGHTNESS_MAX, bmax);
        write_reg(kalc_pkg::REG_REPEAT_DELAY, delay);
        write_reg(kalc_pkg::REG_REPEAT_INTERVAL, intv);
        write_reg(kalc_pkg::REG_SLEEP_GAP, gap);
        write_reg(kalc_pkg::REG_MENU_KEY, menu);
        write_reg(kalc_pkg::REG_PLUS_KEY, plus);
        write_reg(kalc_pkg::REG_MINUS_KEY, minus);
        settings_used = settings_used + 1;
    endtask

    // wait until every queued beat is in and every report is out, then let
    // the pipe settle
    task automatic drain_pipeline();
        while (beats_taken != beats_queued || level_reports_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_GAP) @(negedge aclk);
    endtask

    // a level biased toward the saturation points
    function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] cap);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return cap;
            2: return cap + LEVEL_W'(1);
            default: return LEVEL_W'($urandom_range(0, 63));
        endcase
    endfunction

    // one well-formed frame: start, up to three key events, end
    task automatic queue_frame(input logic hold);
        logic [31:0]       t;
        logic [CODE_W-1:0] code;
        logic [1:0]        value;
        int unsigned       span, n;
        span = ($urandom_range(0, 1) != 0) ? 32'(interval_cfg) : 32'(delay_cfg);
        case ($urandom_range(0, 19))
            0:       t = $urandom();
            1, 2:    t = stim_clock + 32'(gap_cfg) + $urandom_range(1, 50);
            default: t = stim_clock + $urandom_range(0, span + 20);
        endcase
        stim_clock = t;
        push_beat(kalc_pkg::KIND_FRAME_START, t, 1'b1, CODE_W'($urandom()), 2'($urandom()),
                  LEVEL_W'($urandom()), LEVEL_W'($urandom()), hold);
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0, 1:    code = menu_code;
                2, 3, 4: code = plus_code;
                5, 6:    code = minus_code;
                default: code = CODE_W'($urandom());
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = kalc_pkg::KEY_PRESSED;
                4, 5:       value = kalc_pkg::KEY_REPEAT;
                6, 7, 8:    value = kalc_pkg::KEY_RELEASED;
                default:    value = KEY_IGNORED;
            endcase
            push_beat(kalc_pkg::KIND_KEY_EVENT, $urandom(), $urandom_range(0, 15) != 0,
                      code, value, LEVEL_W'($urandom()), LEVEL_W'($urandom()), 1'b0);
        end
        push_beat(kalc_pkg::KIND_FRAME_END, $urandom(), 1'($urandom_range(0, 1)),
                  CODE_W'($urandom()), 2'($urandom()), pick_level(vol_cap),
                  pick_level(bri_cap), 1'b0);
    endtask

    // random phase: mostly whole frames, some loose beats of any kind
    task automatic run_phase(input int unsigned target);
        int unsigned start;
        int unsigned frames;
        start  = beats_queued;
        frames = 0;
        stim_clock = last_stamp;
        while (beats_queued - start < target) begin
            if ($urandom_range(0, 9) == 0)
                push_beat(2'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                          CODE_W'($urandom()), 2'($urandom()),
                          LEVEL_W'($urandom()), LEVEL_W'($urandom()), 1'b0);
            else
                queue_frame(frames % 60 == 30);
            frames = frames + 1;
        end
        drain_pipeline();
    endtask

    initial begin
        logic [15:0] pick;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        beat_taken    = 1'b0;
        steady_run    = 1'b0;
        beats_queued  = 0;
        beats_taken   = 0;
        reports_checked = 0;
        settings_used = 1;
        fails         = 0;
        cycles        = 0;
        stim_clock    = '0;
        // register defaults after reset
        vol_cap      = kalc_pkg::VOLUME_MAX_RST;
        bri_cap      = kalc_pkg::BRIGHTNESS_MAX_RST;
        delay_cfg    = kalc_pkg::REPEAT_DELAY_RST;
        interval_cfg = kalc_pkg::REPEAT_INTERVAL_RST;
        gap_cfg      = kalc_pkg::SLEEP_GAP_RST;
        menu_code    = kalc_pkg::MENU_KEY_RST;
        plus_code    = kalc_pkg::PLUS_KEY_RST;
        minus_code   = kalc_pkg::MINUS_KEY_RST;
        // key state after reset
        cur_stamp  = '0;
        last_stamp = '0;
        raise_due  = '0;
        lower_due  = '0;
        skip_frame = 1'b0;
        menu_on    = 1'b0;
        raise_held = 1'b0;
        raise_new  = 1'b0;
        lower_held = 1'b0;
        lower_new  = 1'b0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames on the reset defaults
        // fresh press steps volume up
        push_beat(kalc_pkg::KIND_FRAME_START, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::PLUS_KEY_RST,
                  kalc_pkg::KEY_PRESSED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd5, 6'd3, 1'b0);
        // held key before the repeat delay does nothing
        push_beat(kalc_pkg::KIND_FRAME_START, 32'd100, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd6, 6'd3, 1'b0);
        // first repeat with the level already above its maximum
        push_beat(kalc_pkg::KIND_FRAME_START, 32'd400, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd63, 6'd63, 1'b0);
        // menu held, minus via repeat value, then events that must be dropped
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::MENU_KEY_RST,
                  kalc_pkg::KEY_PRESSED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::MINUS_KEY_RST,
                  kalc_pkg::KEY_REPEAT, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b0, kalc_pkg::PLUS_KEY_RST,
                  kalc_pkg::KEY_RELEASED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::PLUS_KEY_RST,
                  KEY_IGNORED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, 10'd1023,
                  kalc_pkg::KEY_PRESSED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd0, 6'd0, 1'b0);
        // unused kind with every field at its top
        push_beat(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 10'd1023, KEY_IGNORED, 6'd63, 6'd63, 1'b0);
        // frame end with no start
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd20, 6'd10, 1'b0);
        // long sleep gap discards the frame and clears the key state
        push_beat(kalc_pkg::KIND_FRAME_START, 32'hFFFF_FFFF, 1'b1, 10'd0,
                  kalc_pkg::KEY_RELEASED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::PLUS_KEY_RST,
                  kalc_pkg::KEY_PRESSED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd63, 6'd0, 1'b0);
        // time wraps past zero inside the gap; sender waits for all reports first
        push_beat(kalc_pkg::KIND_FRAME_START, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd0, 6'd0, 1'b1);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::MINUS_KEY_RST,
                  kalc_pkg::KEY_PRESSED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, 10'd0,
                  kalc_pkg::KEY_PRESSED, 6'd0, 6'd0, 1'b0);
        // down step on zero writes nothing
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::MINUS_KEY_RST,
                  kalc_pkg::KEY_RELEASED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_KEY_EVENT, 32'd0, 1'b1, kalc_pkg::MENU_KEY_RST,
                  kalc_pkg::KEY_RELEASED, 6'd0, 6'd0, 1'b0);
        push_beat(kalc_pkg::KIND_FRAME_END, 32'd0, 1'b1, 10'd0, kalc_pkg::KEY_RELEASED,
                  6'd33, 6'd33, 1'b0);
        drain_pipeline();

        // random traffic on the defaults
        run_phase(300);

        // every level limit and time register at its top
        load_settings(16'd63, 16'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'd1023, 16'd512, 16'd1);
        run_phase(300);

        // every limit at zero, menu and plus share a code
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1023);
        run_phase(150);

        // random limits, plus and minus share a code, no idling on either side
        pick = 16'($urandom_range(0, 1023));
        load_settings(16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
                      16'($urandom_range(0, 600)), 16'($urandom_range(0, 200)),
                      16'($urandom_range(200, 3000)), 16'($urandom_range(0, 1023)),
                      pick, pick);
        steady_run = 1'b1;
        run_phase(300);
        steady_run = 1'b0;

        // random limits and codes
        load_settings(16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
                      16'($urandom_range(0, 2000)), 16'($urandom_range(0, 500)),
                      16'($urandom_range(0, 4000)), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
        run_phase(300);

        repeat (10) @(negedge aclk);
        $display("covered %0d input beats and %0d level reports over %0d register settings",
                 beats_taken, reports_checked, settings_used);
        $display("frames included repeats, sleep discards, saturation and shared key codes");
        if (fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kalc_pkg.sv
rtl/core/key_autorepeat_level_control_core.sv
rtl/core/kalc_checker.sv
bench/key_autorepeat_level_control_core_test.sv
